// File: hw/rtl/mix13_mds_round_permutation_core_assert.svh
// Assertion helpers for the Mix13/MDS permutation core.
`ifndef MIX13_MDS_ROUND_PERMUTATION_CORE_ASSERT_SVH
`define MIX13_MDS_ROUND_PERMUTATION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MIX13_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MIX13_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MIX13_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MIX13_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/mix13_mds_pkg.sv
package mix13_mds_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 64;
  localparam int BYTE_W = 8;
  localparam int RC_W   = 3;
  // wide enough for any supported round limit (up to 8)
  localparam int RND_W  = 4;

  localparam int SHIFT_1 = 30;
  localparam int SHIFT_2 = 27;
  localparam int SHIFT_3 = 31;

  localparam logic [LANE_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [LANE_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;
  localparam logic [BYTE_W-1:0] GF_TOP_BIT  = 8'h80;

  localparam logic [BYTE_W-1:0] MDS_COEF [LANES] = '{
    8'd1, 8'd1, 8'd4, 8'd1, 8'd8, 8'd5, 8'd2, 8'd9
  };

  localparam logic [RC_W-1:0] RC_RESET = 3'd2;

  typedef logic [LANES-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic             valid;
    logic [RND_W-1:0] rounds;
  } ctrl_t;

  function automatic logic [BYTE_W-1:0] gf_double(logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] d;
    d = {v[BYTE_W-2:0], 1'b0};
    if ((v & GF_TOP_BIT) != '0) begin
      d = d ^ GF_POLY_LOW;
    end
    return d;
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] x;
    acc = '0;
    x   = v;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[b]) begin
        acc = acc ^ x;
      end
      x = gf_double(x);
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/mix13_mds_lane_if.sv
interface mix13_mds_lane_if;
  logic        valid;
  logic        ready;
  logic [63:0] lane_0;
  logic [63:0] lane_1;
  logic [63:0] lane_2;
  logic [63:0] lane_3;
  logic [63:0] lane_4;
  logic [63:0] lane_5;
  logic [63:0] lane_6;
  logic [63:0] lane_7;

  modport source (
    output valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7,
    input  ready
  );
  modport sink (
    input  valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7,
    output ready
  );
endinterface

// File: hw/rtl/mix13_mds_cfg_if.sv
interface mix13_mds_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] round_count;

  modport source (output valid, round_count, input ready);
  modport sink (input valid, round_count, output ready);
endinterface

// File: hw/rtl/mix13_mds_lane.sv
module mix13_mds_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [mix13_mds_pkg::LANE_W-1:0] lane_in,
  output logic [mix13_mds_pkg::LANE_W-1:0] lane_out
);
  import mix13_mds_pkg::*;

  localparam int HW = LANE_W / 2;

  // 64x64 mod 2^64 = lo*lo + ((hi*lo + lo*hi) << 32), cross terms low half only
  logic [LANE_W-1:0] x;
  logic [LANE_W-1:0] a_ll_nxt;
  logic [HW-1:0]     a_hl_nxt;
  logic [HW-1:0]     a_lh_nxt;
  logic [LANE_W-1:0] a_ll_r;
  logic [HW-1:0]     a_hl_r;
  logic [HW-1:0]     a_lh_r;

  logic [LANE_W-1:0] y;
  logic [LANE_W-1:0] y2;
  logic [LANE_W-1:0] b_ll_nxt;
  logic [HW-1:0]     b_hl_nxt;
  logic [HW-1:0]     b_lh_nxt;
  logic [LANE_W-1:0] b_ll_r;
  logic [HW-1:0]     b_hl_r;
  logic [HW-1:0]     b_lh_r;

  logic [LANE_W-1:0] w;

  always_comb begin
    x        = lane_in ^ (lane_in >> SHIFT_1);
    a_ll_nxt = LANE_W'(x[HW-1:0]) * LANE_W'(MIX_MUL_A[HW-1:0]);
    a_hl_nxt = HW'(x[LANE_W-1:HW] * MIX_MUL_A[HW-1:0]);
    a_lh_nxt = HW'(x[HW-1:0] * MIX_MUL_A[LANE_W-1:HW]);
  end

  always_comb begin
    y        = a_ll_r + {HW'(a_hl_r + a_lh_r), HW'(0)};
    y2       = y ^ (y >> SHIFT_2);
    b_ll_nxt = LANE_W'(y2[HW-1:0]) * LANE_W'(MIX_MUL_B[HW-1:0]);
    b_hl_nxt = HW'(y2[LANE_W-1:HW] * MIX_MUL_B[HW-1:0]);
    b_lh_nxt = HW'(y2[HW-1:0] * MIX_MUL_B[LANE_W-1:HW]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ll_r <= a_ll_nxt;
      a_hl_r <= a_hl_nxt;
      a_lh_r <= a_lh_nxt;
      b_ll_r <= b_ll_nxt;
      b_hl_r <= b_hl_nxt;
      b_lh_r <= b_lh_nxt;
    end
  end

  always_comb begin
    w        = b_ll_r + {HW'(b_hl_r + b_lh_r), HW'(0)};
    lane_out = w ^ (w >> SHIFT_3);
  end

endmodule

// File: hw/rtl/mix13_mds_round.sv
module mix13_mds_round #(
  parameter int ROUND_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  mix13_mds_pkg::ctrl_t  ctrl_in,
  input  mix13_mds_pkg::lanes_t state_in,
  output mix13_mds_pkg::ctrl_t  ctrl_out,
  output mix13_mds_pkg::lanes_t state_out
);
  import mix13_mds_pkg::*;

  ctrl_t  ctrl_s1_r;
  ctrl_t  ctrl_s2_r;
  ctrl_t  ctrl_out_r;
  lanes_t byp_s1_r;
  lanes_t byp_s2_r;
  lanes_t state_out_r;
  lanes_t mixed;
  lanes_t mds;
  logic   active;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mix13_mds_lane u_lane (
      .clk      (clk),
      .en       (en),
      .lane_in  (state_in[g]),
      .lane_out (mixed[g])
    );
  end

  // merge: byte transpose plus circulant MDS, big-endian byte order
  always_comb begin
    logic [BYTE_W-1:0] acc;
    for (int j = 0; j < LANES; j++) begin
      for (int i = 0; i < LANES; i++) begin
        acc = '0;
        for (int k = 0; k < LANES; k++) begin
          acc = acc ^ gf_mul(mixed[k][LANE_W-1-BYTE_W*j -: BYTE_W],
                             MDS_COEF[(i - k) & (LANES - 1)]);
        end
        mds[j][LANE_W-1-BYTE_W*i -: BYTE_W] = acc;
      end
    end
  end

  assign active = ctrl_s2_r.rounds > RND_W'(ROUND_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_s1_r  <= '0;
      ctrl_s2_r  <= '0;
      ctrl_out_r <= '0;
    end else if (en) begin
      ctrl_s1_r  <= ctrl_in;
      ctrl_s2_r  <= ctrl_s1_r;
      ctrl_out_r <= ctrl_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_s1_r    <= state_in;
      byp_s2_r    <= byp_s1_r;
      state_out_r <= active ? mds : byp_s2_r;
    end
  end

  assign ctrl_out  = ctrl_out_r;
  assign state_out = state_out_r;

endmodule

// File: hw/rtl/mix13_mds_round_permutation_core.sv
// Mix13 finalizer + GF(2^8) MDS round permutation over a 512-bit state.
// in_ch : valid/ready channel, one transaction is one state of eight 64-bit
//         lanes (lane_0..lane_7).
// out_ch: valid/ready channel, one permuted state per input transaction, in
//         input order.
// cfg_ch: valid/ready write of round_count (0..7, saturates at MAX_ROUNDS);
//         ready is always high. Write it only while the core is empty.
// Every state passes through all MAX_ROUNDS round units from input to output,
// independent of round_count: each round unit has three stages, two for the
// split 64-bit multiplies of the eight lane mixers and one for the MDS merge.
// Throughput is one state per cycle unless out_ch stalls. Rounds beyond
// round_count pass the state through unchanged.
// When out_ch is stalled with a result pending, the whole pipeline holds and
// in_ch.ready drops in the same cycle.
// Reset (rst_n low, synchronous) empties the pipeline and sets round_count
// to 2.
module mix13_mds_round_permutation_core #(
  parameter int MAX_ROUNDS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  mix13_mds_lane_if.sink          in_ch,
  mix13_mds_lane_if.source        out_ch,
  mix13_mds_cfg_if.sink           cfg_ch
);
  import mix13_mds_pkg::*;

`include "mix13_mds_round_permutation_core_assert.svh"

  logic [RC_W-1:0]  round_count_r;
  logic [RND_W-1:0] rounds_sat;
  logic             adv;
  ctrl_t            ctrl_chain  [MAX_ROUNDS+1];
  lanes_t           state_chain [MAX_ROUNDS+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= RC_RESET;
    end else if (cfg_ch.valid) begin
      round_count_r <= cfg_ch.round_count;
    end
  end

  always_comb begin
    if (RND_W'(round_count_r) > RND_W'(MAX_ROUNDS)) begin
      rounds_sat = RND_W'(MAX_ROUNDS);
    end else begin
      rounds_sat = RND_W'(round_count_r);
    end
  end

  // global advance: the last round register doubles as the output register
  assign adv         = !ctrl_chain[MAX_ROUNDS].valid || out_ch.ready;
  assign in_ch.ready = adv;

  assign ctrl_chain[0].valid  = in_ch.valid;
  assign ctrl_chain[0].rounds = rounds_sat;
  assign state_chain[0]       = {in_ch.lane_7, in_ch.lane_6, in_ch.lane_5, in_ch.lane_4,
                                 in_ch.lane_3, in_ch.lane_2, in_ch.lane_1, in_ch.lane_0};

  for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
    mix13_mds_round #(
      .ROUND_IDX (r)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .ctrl_in   (ctrl_chain[r]),
      .state_in  (state_chain[r]),
      .ctrl_out  (ctrl_chain[r+1]),
      .state_out (state_chain[r+1])
    );
  end

  assign out_ch.valid  = ctrl_chain[MAX_ROUNDS].valid;
  assign out_ch.lane_0 = state_chain[MAX_ROUNDS][0];
  assign out_ch.lane_1 = state_chain[MAX_ROUNDS][1];
  assign out_ch.lane_2 = state_chain[MAX_ROUNDS][2];
  assign out_ch.lane_3 = state_chain[MAX_ROUNDS][3];
  assign out_ch.lane_4 = state_chain[MAX_ROUNDS][4];
  assign out_ch.lane_5 = state_chain[MAX_ROUNDS][5];
  assign out_ch.lane_6 = state_chain[MAX_ROUNDS][6];
  assign out_ch.lane_7 = state_chain[MAX_ROUNDS][7];

  `MIX13_ASSERT_IMP(a_stall_blocks_input, clk, rst_n,
    out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken while output stalled")
  `MIX13_ASSERT_NXT(a_cfg_write_lands, clk, rst_n,
    cfg_ch.valid && cfg_ch.ready, round_count_r == $past(cfg_ch.round_count),
    "round count write lost")
  `MIX13_ASSERT_IMP(a_rounds_saturated, clk, rst_n,
    ctrl_chain[MAX_ROUNDS].valid, ctrl_chain[MAX_ROUNDS].rounds <= RND_W'(MAX_ROUNDS),
    "round count above limit reached output")

endmodule
